// ===== design/pctd_pkg.sv =====
// Package for the percent-escape decoder: command type passed from the front
// to the back, queue status, character constants and the hex digit decoder.
// No dependencies.
package pctd_pkg;

    // Character codes.
    localparam logic [7:0] PCT_CHAR   = 8'h25;
    localparam logic [7:0] DIGIT_BASE = 8'h30;
    localparam logic [7:0] UPPER_BASE = 8'h37;
    localparam logic [7:0] LOWER_BASE = 8'h57;
    localparam logic [7:0] UPPER_A    = 8'h41;
    localparam logic [7:0] LOWER_A    = 8'h61;

    // Default depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // One classified item: up to three bytes to emit, their count, and the
    // string-end flag of the item that caused them.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      cnt;
        logic            last;
    } t_cmd;

    // Queue status seen by the front and the back.
    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

    // Hex digit decode: bit 4 is the valid flag, bits 3:0 the value.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (c >= DIGIT_BASE && c <= 8'h39) begin
            d = c - DIGIT_BASE;
            return {1'b1, d[3:0]};
        end else if (c >= UPPER_A && c <= 8'h46) begin
            d = c - UPPER_BASE;
            return {1'b1, d[3:0]};
        end else if (c >= LOWER_A && c <= 8'h66) begin
            d = c - LOWER_BASE;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

// ===== design/pctd_if.sv =====
// Handshake interfaces for the percent-escape decoder channels.
// Depends on nothing; carries valid, ready and the item payload.
interface pctd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface pctd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;

    modport source (output valid, output out_byte, output run_last,
                    output string_end, input ready);
    modport sink   (input valid, input out_byte, input run_last,
                    input string_end, output ready);
endinterface

// ===== design/percent_escape_decoder.sv =====
// Percent-escape decoder top level: front classifier, command queue, back
// expander. Depends on pctd_pkg, pctd_if and the pctd_* modules.
//
//   channel   direction   payload                          handshake
//   i_in      in          in_byte[7:0], in_last            valid / ready
//   o_out     out         out_byte[7:0], run_last,         valid / ready
//                         string_end
//
// One input item is taken per cycle while the queue has room. Each item
// leaves zero to three bytes; the output register sends one byte per cycle
// while the receiver is ready, so an item with two or three bytes holds the
// back and the queue (QUEUE_DEPTH commands) fills behind it. Results pass
// through the queue, then the output register. Reset is synchronous,
// active low, and clears the escape phase, queue and output valid.
module percent_escape_decoder #(
    parameter int QUEUE_DEPTH = pctd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pctd_in_if.sink     i_in,
    pctd_out_if.source  o_out
);

    pctd_pkg::t_cmd    cmd;
    pctd_pkg::t_cmd    head;
    pctd_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;

    // Classify input items.
    pctd_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    // Decouple front and back.
    pctd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Emit decoded bytes.
    pctd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // A command is never pushed into a full queue.
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !q_stat.full)
        else $error("command pushed into a full queue");

    // Popping a command always presents its final byte next.
    a_pop_run_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> (o_out.valid && o_out.run_last))
        else $error("popped command did not end its run");

    // The end of a string is only flagged on the end of a run.
    a_end_on_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.string_end) |-> o_out.run_last)
        else $error("string end flagged mid run");

    // A pop only happens with a command waiting.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_stat.nonempty)
        else $error("pop from an empty queue");

endmodule

// ===== design/pctd_front.sv =====
// Front end of the percent-escape decoder: accepts input items, tracks the
// escape phase and turns each item that produces bytes into a queue command.
// Depends on pctd_pkg and pctd_if.
module pctd_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pctd_in_if.sink            i_in,
    input  pctd_pkg::t_q_stat  i_q_stat,
    output logic               o_push,
    output pctd_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, n_first;
    logic       accept;
    logic [4:0] hex_c;
    logic [4:0] hex_f;

    assign i_in.ready = !i_q_stat.full;
    assign accept     = i_in.valid && i_in.ready;
    assign hex_c      = pctd_pkg::hex_decode(i_in.in_byte);
    assign hex_f      = pctd_pkg::hex_decode(r_first);

    // Classify the current byte against the pending escape.
    always_comb begin
        n_phase         = r_phase;
        n_first         = r_first;
        o_cmd.bytes     = '0;
        o_cmd.cnt       = 2'd0;
        o_cmd.last      = i_in.in_last;
        case (r_phase)
            PH_PCT: begin
                if (!i_in.in_last && hex_c[4]) begin
                    n_first = i_in.in_byte;
                    n_phase = PH_DIGIT;
                end else begin
                    o_cmd.bytes[0] = pctd_pkg::PCT_CHAR;
                    o_cmd.bytes[1] = i_in.in_byte;
                    o_cmd.cnt      = 2'd2;
                    n_phase        = PH_IDLE;
                end
            end
            PH_DIGIT: begin
                if (hex_c[4] && hex_f[4]) begin
                    o_cmd.bytes[0] = {hex_f[3:0], hex_c[3:0]};
                    o_cmd.cnt      = 2'd1;
                end else begin
                    o_cmd.bytes[0] = pctd_pkg::PCT_CHAR;
                    o_cmd.bytes[1] = r_first;
                    o_cmd.bytes[2] = i_in.in_byte;
                    o_cmd.cnt      = 2'd3;
                end
                n_phase = PH_IDLE;
            end
            default: begin
                if (i_in.in_byte == pctd_pkg::PCT_CHAR && !i_in.in_last) begin
                    n_phase = PH_PCT;
                end else begin
                    o_cmd.bytes[0] = i_in.in_byte;
                    o_cmd.cnt      = 2'd1;
                    n_phase        = PH_IDLE;
                end
            end
        endcase
    end

    // Only items that produce bytes enter the queue.
    assign o_push = accept && (o_cmd.cnt != 2'd0);

    // Escape state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_first <= 8'h00;
        end else if (accept) begin
            r_phase <= n_phase;
            r_first <= n_first;
        end
    end

endmodule

// ===== design/pctd_queue.sv =====
// Command queue between the front and back of the percent-escape decoder.
// A small circular buffer of flip-flops; depends on pctd_pkg.
module pctd_queue #(
    parameter int DEPTH = pctd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pctd_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output pctd_pkg::t_cmd    o_head,
    output pctd_pkg::t_q_stat o_stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pctd_pkg::t_cmd   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_stat.full     = (r_count == FULL_CNT);
    assign o_stat.nonempty = (r_count != '0);
    assign do_push         = i_push && !o_stat.full;
    assign do_pop          = i_pop && o_stat.nonempty;
    assign o_head          = r_mem[r_rd];

    // Storage; no reset needed for payload.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/pctd_back.sv =====
// Back end of the percent-escape decoder: walks the bytes of the queue head
// into a registered output stage. Depends on pctd_pkg and pctd_if.
module pctd_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pctd_pkg::t_cmd    i_head,
    input  pctd_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    pctd_out_if.source        o_out
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_string_end;
    logic       load;
    logic       at_end;
    logic [7:0] sel_byte;

    assign load   = i_q_stat.nonempty && (!r_valid || o_out.ready);
    assign at_end = (r_idx == (i_head.cnt - 2'd1));
    assign o_pop  = load && at_end;

    // Pick the byte of the head command that goes out next.
    always_comb begin
        case (r_idx)
            2'd0:    sel_byte = i_head.bytes[0];
            2'd1:    sel_byte = i_head.bytes[1];
            2'd2:    sel_byte = i_head.bytes[2];
            default: sel_byte = 8'h00;
        endcase
    end

    // Output register and byte index.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_end ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte       <= sel_byte;
            r_run_last   <= at_end;
            r_string_end <= at_end && i_head.last;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.out_byte   = r_byte;
    assign o_out.run_last   = r_run_last;
    assign o_out.string_end = r_string_end;

endmodule
